### sv/htf_pkg.sv
// Shared types, constants and command codes for the Hermite table FIR.
package htf_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int CFG_IDX_BITS    = 3;
    localparam int CFG_DATA_BITS   = 32;
    localparam int SUM_BITS        = 40;
    localparam int ACC_BITS        = 48;
    localparam int IDX_BITS        = 17;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_FRAME = 2'd1,
        CMD_EVAL  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        CFG_OFFSET   = 3'd0,
        CFG_STEP     = 3'd1,
        CFG_INV_STEP = 3'd2,
        CFG_STRIDE   = 3'd3,
        CFG_LENGTH   = 3'd4,
        CFG_STEREO   = 3'd5
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOC1,
        ST_LOC2,
        ST_LOC3,
        ST_LOC4,
        ST_LOC5,
        ST_RD,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_ACC,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [9:0]         entry_index;
        logic signed [31:0] entry_value;
        logic signed [31:0] entry_slope;
        logic signed [31:0] position;
        logic               first_frame;
        logic               last_frame;
        logic signed [SAMPLE_BITS_DEF-1:0] sample_left;
        logic signed [SAMPLE_BITS_DEF-1:0] sample_right;
    } in_beat_t;

    typedef struct packed {
        logic signed [SUM_BITS-1:0] sum_left;
        logic signed [SUM_BITS-1:0] sum_right;
        logic                       range_error;
        logic                       result_kind;
    } out_beat_t;

endpackage

### sv/hermite_table_fir.sv
// Hermite table FIR: kernel table in two memories, sequential tap engine.
// Usage:
//   in channel (in_valid/in_stall/in_data) carries write, frame and evaluate
//   beats; out channel (out_valid/out_stall/out_data) carries one result per
//   last frame or evaluate. Config registers are written through cfg_we,
//   cfg_index, cfg_data while the block is idle.
// Sequencing:
//   A table write is accepted in the idle state. A frame that continues a run
//   keeps in_stall high after its beat through ST_RD (entry i, then i+1),
//   ST_MUL0 to ST_MUL3 (sharing one 33x33 multiplier) and ST_ACC, so a new
//   frame is taken only once the last is through. A first frame or an
//   evaluate first passes ST_LOC1 to ST_LOC5 (a spare step after the offset
//   subtract, scale by inverse step, fraction square, cube, slope weights).
//   A last frame or an evaluate adds ST_OUT. The result register holds the
//   last beat; a new item is accepted while it waits, and the engine only
//   pauses in its output step if the previous result is still unread.
// Reset: rst_n clears the registers to their reset values and empties the
//   engine and result register. Table contents are undefined until written.
// Stall: out_stall holds out_data stable; in_stall rises while the engine is busy.
module hermite_table_fir
    import htf_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  htf_pkg::in_beat_t        in_data,
    output logic                     out_valid,
    input  logic                     out_stall,
    output htf_pkg::out_beat_t       out_data,
    input  logic                     cfg_we,
    input  logic [htf_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [htf_pkg::CFG_DATA_BITS-1:0] cfg_data
);
    localparam int AW = $clog2(TABLE_DEPTH);

    // configuration
    logic signed [31:0] offset_reg;
    logic [30:0] step_reg, inv_step_reg;
    logic [9:0]  stride_reg, length_reg;
    logic        stereo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg   <= '0;
            step_reg     <= 31'd65536;
            inv_step_reg <= 31'd65536;
            stride_reg   <= 10'd1;
            length_reg   <= 10'd1023;
            stereo_reg   <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_OFFSET:   offset_reg   <= cfg_data;
                CFG_STEP:     step_reg     <= cfg_data[30:0];
                CFG_INV_STEP: inv_step_reg <= cfg_data[30:0];
                CFG_STRIDE:   stride_reg   <= cfg_data[9:0];
                CFG_LENGTH:   length_reg   <= cfg_data[9:0];
                CFG_STEREO:   stereo_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // table memories: one entry per address; pair read as two banks by parity
    // is avoided by reading entries i and i+1 in consecutive cycles.
    logic signed [31:0] vmem [TABLE_DEPTH];
    logic signed [31:0] smem [TABLE_DEPTH];
    logic [AW-1:0]      rd_addr;
    logic signed [31:0] v_rd, s_rd;

    logic in_acc;
    state_t st_reg, st_next;
    in_beat_t item_reg;

    always_ff @(posedge clk)
    begin
        if (in_acc && in_data.cmd == CMD_WRITE &&
            17'(in_data.entry_index) < 17'(TABLE_DEPTH))
        begin
            vmem[AW'(in_data.entry_index)] <= in_data.entry_value;
            smem[AW'(in_data.entry_index)] <= in_data.entry_slope;
        end
        v_rd <= vmem[rd_addr];
        s_rd <= smem[rd_addr];
    end

    // engine state
    logic signed [ACC_BITS-1:0] accl_reg, accr_reg;
    logic signed [IDX_BITS-1:0] idx_reg;
    logic [16:0]               f0_reg, f1_reg;
    logic signed [31:0]        w0_reg, w1_reg;
    logic                      flag_reg;

    // evaluate position, kept apart so a run in progress is not disturbed
    logic signed [IDX_BITS-1:0] eidx_reg;
    logic [16:0]               ef0_reg, ef1_reg;
    logic signed [31:0]        ew0_reg, ew1_reg;

    // locate scratch
    logic signed [32:0] d_reg;
    logic signed [64:0] u_reg;
    logic [15:0]        t_reg, t2_reg, t3_reg;

    // tap scratch
    logic               eval_reg, bad_reg, rd_phase_reg;
    logic signed [31:0] v0_reg, s0_reg, v1_reg, s1_reg;
    logic signed [63:0] c_reg;
    logic signed [31:0] coef_reg;

    logic      ov_reg;
    out_beat_t od_reg;
    out_beat_t res_reg;
    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    assign in_stall = (st_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;

    logic signed [IDX_BITS-1:0] idx_cur;
    logic [16:0]               f0_cur, f1_cur;
    logic signed [31:0]        w0_cur, w1_cur;
    assign idx_cur = eval_reg ? eidx_reg : idx_reg;
    assign f0_cur  = eval_reg ? ef0_reg : f0_reg;
    assign f1_cur  = eval_reg ? ef1_reg : f1_reg;
    assign w0_cur  = eval_reg ? ew0_reg : w0_reg;
    assign w1_cur  = eval_reg ? ew1_reg : w1_reg;

    // shared multiplier
    logic signed [32:0] ma, mb;
    logic signed [65:0] mp;
    assign mp = ma * mb;

    logic bad_c;
    logic signed [17:0] idx_p1;
    assign idx_p1 = 18'(idx_cur) + 18'sd1;
    assign bad_c = idx_cur < 0 || idx_p1 > $signed({8'd0, length_reg}) ||
                   idx_p1 >= $signed(18'(TABLE_DEPTH));
    assign rd_addr = rd_phase_reg ? AW'(idx_p1) : AW'(idx_cur);

    always_comb
    begin
        ma = '0;
        mb = '0;
        unique case (st_reg)
            ST_LOC2:
            begin
                ma = d_reg;
                mb = {2'b0, inv_step_reg};
            end
            ST_LOC3:
            begin
                ma = {17'd0, t_reg};
                mb = {17'd0, t_reg};
            end
            ST_LOC4:
            begin
                ma = {17'd0, t2_reg};
                mb = {17'd0, t_reg};
            end
            ST_MUL0:
            begin
                ma = 33'(v0_reg);
                mb = {16'd0, f0_cur};
            end
            ST_MUL1:
            begin
                ma = 33'(v1_reg);
                mb = {16'd0, f1_cur};
            end
            ST_MUL2:
            begin
                ma = 33'(s0_reg);
                mb = 33'(w0_cur);
            end
            ST_MUL3:
            begin
                ma = 33'(s1_reg);
                mb = 33'(w1_cur);
            end
            ST_ACC:
            begin
                ma = 33'(item_reg.sample_left);
                mb = 33'(coef_reg);
            end
            default: ;
        endcase
    end

    // separate multipliers in the slope-weight and right-channel steps
    logic signed [33:0] hw0, hw1;
    logic signed [65:0] mw0, mw1;
    assign hw0 = 34'($signed({18'd0, t_reg})) - 34'($signed({17'd0, t2_reg, 1'b0}))
               + 34'($signed({18'd0, t3_reg}));
    assign hw1 = 34'($signed({18'd0, t3_reg})) - 34'($signed({18'd0, t2_reg}));
    assign mw0 = hw0 * $signed({2'b0, step_reg});
    assign mw1 = hw1 * $signed({2'b0, step_reg});

    logic signed [65:0] mr;
    assign mr = 33'(item_reg.sample_right) * 33'(coef_reg);

    function automatic logic signed [ACC_BITS-1:0] sat_acc(input logic signed [ACC_BITS:0] v);
        if (v > $signed((ACC_BITS+1)'({1'b0, {(ACC_BITS-1){1'b1}}})))
            return {1'b0, {(ACC_BITS-1){1'b1}}};
        if (v < $signed(-(ACC_BITS+1)'({1'b0, {(ACC_BITS-1){1'b1}}}) - 1))
            return {1'b1, {(ACC_BITS-1){1'b0}}};
        return v[ACC_BITS-1:0];
    endfunction

    function automatic logic signed [SUM_BITS-1:0] sat_sum(input logic signed [ACC_BITS-1:0] v);
        if (v > $signed(ACC_BITS'({1'b0, {(SUM_BITS-1){1'b1}}})))
            return {1'b0, {(SUM_BITS-1){1'b1}}};
        if (v < -$signed(ACC_BITS'({1'b0, {(SUM_BITS-1){1'b1}}})) - 1)
            return {1'b1, {(SUM_BITS-1){1'b0}}};
        return v[SUM_BITS-1:0];
    endfunction

    // last product joins the sum, then floor to Q.28 and saturate
    logic signed [63:0] csum, csh;
    logic signed [31:0] coef_c;
    assign csum = c_reg + 64'(mp);
    assign csh = csum >>> 16;
    assign coef_c = (csh > 64'sh7FFFFFFF) ? 32'sh7FFFFFFF :
                    (csh < -64'sh80000000) ? 32'sh80000000 : csh[31:0];

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE:
                if (in_acc)
                begin
                    if (in_data.cmd == CMD_EVAL ||
                        (in_data.cmd == CMD_FRAME && in_data.first_frame))
                        st_next = ST_LOC1;
                    else if (in_data.cmd == CMD_FRAME)
                        st_next = ST_RD;
                end
            ST_LOC1: st_next = ST_LOC2;
            ST_LOC2: st_next = ST_LOC3;
            ST_LOC3: st_next = ST_LOC4;
            ST_LOC4: st_next = ST_LOC5;
            ST_LOC5: st_next = ST_RD;
            ST_RD:   st_next = rd_phase_reg ? ST_MUL0 : ST_RD;
            ST_MUL0: st_next = ST_MUL1;
            ST_MUL1: st_next = ST_MUL2;
            ST_MUL2: st_next = ST_MUL3;
            ST_MUL3: st_next = ST_ACC;
            ST_ACC:  st_next = (eval_reg || item_reg.last_frame) ? ST_OUT : ST_IDLE;
            ST_OUT:  st_next = (ov_reg && out_stall) ? ST_OUT : ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg       <= ST_IDLE;
            ov_reg       <= 1'b0;
            accl_reg     <= '0;
            accr_reg     <= '0;
            idx_reg      <= '0;
            f0_reg       <= '0;
            f1_reg       <= '0;
            w0_reg       <= '0;
            w1_reg       <= '0;
            eidx_reg     <= '0;
            ef0_reg      <= '0;
            ef1_reg      <= '0;
            ew0_reg      <= '0;
            ew1_reg      <= '0;
            flag_reg     <= 1'b0;
            rd_phase_reg <= 1'b0;
            eval_reg     <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (st_reg == ST_OUT && !(ov_reg && out_stall))
                ov_reg <= 1'b1;
            else if (ov_reg && !out_stall)
                ov_reg <= 1'b0;
            unique case (st_reg)
                ST_IDLE:
                    if (in_acc)
                    begin
                        item_reg     <= in_data;
                        eval_reg     <= (in_data.cmd == CMD_EVAL);
                        rd_phase_reg <= 1'b0;
                        d_reg <= 33'(in_data.position) - 33'(offset_reg);
                    end
                ST_LOC1: ;
                ST_LOC2:
                begin
                    u_reg <= mp[64:0];
                    t_reg <= mp[31:16];
                end
                ST_LOC3: t2_reg <= mp[31:16];
                ST_LOC4: t3_reg <= mp[31:16];
                ST_LOC5:
                begin
                    logic [17:0] f1;
                    logic signed [32:0] ix;
                    f1 = 18'(t2_reg) * 18'd3 - 18'(t3_reg) * 18'd2;
                    ix = u_reg[64:32];
                    if (ix < -33'sd65536)
                        ix = -33'sd65536;
                    else if (ix > 33'sd65535)
                        ix = 33'sd65535;
                    if (eval_reg)
                    begin
                        eidx_reg <= ix[IDX_BITS-1:0];
                        ef1_reg  <= f1[16:0];
                        ef0_reg  <= 17'(18'd65536 - f1);
                        ew0_reg  <= 32'(mw0 >>> 16);
                        ew1_reg  <= 32'(mw1 >>> 16);
                    end
                    else
                    begin
                        accl_reg <= '0;
                        accr_reg <= '0;
                        flag_reg <= 1'b0;
                        idx_reg  <= ix[IDX_BITS-1:0];
                        f1_reg   <= f1[16:0];
                        f0_reg   <= 17'(18'd65536 - f1);
                        w0_reg   <= 32'(mw0 >>> 16);
                        w1_reg   <= 32'(mw1 >>> 16);
                    end
                end
                ST_RD:
                    rd_phase_reg <= 1'b1;
                ST_MUL0:
                begin
                    bad_reg <= bad_c;
                    c_reg   <= 64'(mp);
                end
                ST_MUL1: c_reg <= c_reg + 64'(mp);
                ST_MUL2: c_reg <= c_reg + 64'(mp);
                ST_MUL3:
                    ;
                ST_ACC:
                begin
                    if (eval_reg)
                    begin
                        res_reg.sum_left    <= SUM_BITS'(coef_reg >>> 20);
                        res_reg.sum_right   <= '0;
                        res_reg.range_error <= bad_reg;
                        res_reg.result_kind <= 1'b1;
                    end
                    else
                    begin
                        logic signed [ACC_BITS-1:0] nl, nr;
                        logic signed [IDX_BITS:0] nx;
                        nl = sat_acc((ACC_BITS+1)'(accl_reg) + (ACC_BITS+1)'(mp >>> 20));
                        nr = stereo_reg ?
                             sat_acc((ACC_BITS+1)'(accr_reg) + (ACC_BITS+1)'(mr >>> 20)) :
                             accr_reg;
                        nx = (IDX_BITS+1)'(idx_reg) + (IDX_BITS+1)'({1'b0, stride_reg});
                        accl_reg <= nl;
                        accr_reg <= nr;
                        flag_reg <= flag_reg | bad_reg;
                        idx_reg  <= (nx > (IDX_BITS+1)'(65535)) ? IDX_BITS'(65535) :
                                    nx[IDX_BITS-1:0];
                        res_reg.sum_left    <= sat_sum(nl);
                        res_reg.sum_right   <= stereo_reg ? sat_sum(nr) : '0;
                        res_reg.range_error <= flag_reg | bad_reg;
                        res_reg.result_kind <= 1'b0;
                    end
                end
                ST_OUT:
                    if (!(ov_reg && out_stall))
                        od_reg <= res_reg;
                default: ;
            endcase
        end
    end

    // operand capture from memory and coefficient finish (no reset needed)
    always_ff @(posedge clk)
    begin
        if (st_reg == ST_RD && rd_phase_reg)
        begin
            v0_reg <= v_rd;
            s0_reg <= s_rd;
        end
        if (st_reg == ST_MUL0)
        begin
            v1_reg <= v_rd;
            s1_reg <= s_rd;
        end
        if (st_reg == ST_MUL3)
            coef_reg <= bad_reg ? 32'sd0 : coef_c;
    end

endmodule
